// ===== src/euler_rotate_cube_corners_defines.svh =====
// Assertion macros used by the top level of the cube corner rotator.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef EULER_ROTATE_CUBE_CORNERS_DEFINES_SVH
`define EULER_ROTATE_CUBE_CORNERS_DEFINES_SVH
`ifndef SYNTHESIS
`define ERC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erc assertion failed");
`define ERC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erc assertion failed");
`else
`define ERC_ASSERT(label, ante, cons)
`define ERC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/erc_pkg.sv =====
// Package of the cube corner rotator: fixed-point constants, types, helpers.
// Depends on nothing.
package erc_pkg;

  localparam int CORNER_COUNT_DEF = 8;

  localparam logic signed [17:0] Q12_PI      = 18'sd12868;
  localparam logic signed [17:0] Q12_TWO_PI  = 18'sd25736;
  localparam logic signed [17:0] Q12_HALF_PI = 18'sd6434;
  localparam logic signed [17:0] SIN_A       = 18'sd83443;
  localparam logic signed [16:0] SIN_B       = 17'sd26561;

  localparam logic signed [37:0] OUT_MAX = 38'sd8388607;
  localparam logic signed [37:0] OUT_MIN = -38'sd8388608;

  typedef logic signed [17:0] coef_t;

  typedef struct packed {
    logic             valid;
    logic [8:0][17:0] m;
  } mat_t;

  typedef enum logic [2:0] {
    REG_SHIFT_X       = 3'd0,
    REG_SHIFT_Y       = 3'd1,
    REG_SHIFT_Z       = 3'd2,
    REG_CUBE_SIDE     = 3'd3,
    REG_VIEW_DISTANCE = 3'd4
  } reg_idx_t;

  // Product of two Q.14 values rounded to Q.14, ties toward plus infinity.
  function automatic coef_t mul14(input coef_t a, input coef_t b);
    logic signed [35:0] p;
    p = 36'(a) * 36'(b) + 36'sd8192;
    return p[31:14];
  endfunction

  // Corner signs {x, y, z}, a one meaning the positive half side.
  function automatic logic [2:0] corner_sign(input logic [2:0] k);
    logic [2:0] s;
    case (k)
      3'd0:    s = 3'b011;
      3'd1:    s = 3'b111;
      3'd2:    s = 3'b110;
      3'd3:    s = 3'b010;
      3'd4:    s = 3'b001;
      3'd5:    s = 3'b101;
      3'd6:    s = 3'b100;
      default: s = 3'b000;
    endcase
    return s;
  endfunction

endpackage

// ===== src/erc_in_if.sv =====
// Input channel of the cube corner rotator: one beat carries three angles.
// Depends on nothing.
interface erc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// ===== src/erc_out_if.sv =====
// Result channel of the cube corner rotator: one beat carries one corner.
// Depends on nothing.
interface erc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         corner_index;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic signed [23:0] out_z;
  logic               last_corner;

  modport source (output valid, corner_index, out_x, out_y, out_z, last_corner,
                  input ready);
  modport sink (input valid, corner_index, out_x, out_y, out_z, last_corner,
                output ready);
endinterface

// ===== src/erc_matrix.sv =====
// Seven-stage pipeline from three angles to the 3x3 rotation matrix.
// Depends on erc_pkg.
module erc_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [15:0]  ang_x,
  input  logic signed [15:0]  ang_y,
  input  logic signed [15:0]  ang_z,
  output erc_pkg::mat_t       mat
);
  import erc_pkg::*;

  // Sine slots: 0 sx, 1 cx, 2 sy, 3 cy, 4 sz, 5 cz.
  logic [7:1]         v_r;
  logic signed [15:0] w_r   [6];
  logic signed [15:0] w_nxt [6];
  logic signed [33:0] lin2_r [6];
  logic signed [29:0] sq1_r  [6];
  logic [5:0]         neg2_r;
  logic signed [33:0] lin3_r [6];
  logic signed [45:0] sq3_r  [6];
  logic [5:0]         neg3_r;
  coef_t              sn_r   [6];
  logic signed [45:0] sum4   [6];

  coef_t p5_r, q5_r, cz5_r, sz5_r, cxsz5_r, cxcz5_r, sxsz5_r, sxcz5_r;
  coef_t m00_5_r, m01_5_r, m02_5_r, m12_5_r, m22_5_r;
  coef_t pcz6_r, psz6_r, qcz6_r, qsz6_r, cxsz6_r, cxcz6_r, sxsz6_r, sxcz6_r;
  coef_t m00_6_r, m01_6_r, m02_6_r, m12_6_r, m22_6_r;
  logic [8:0][17:0]   m7_r;

  always_comb begin
    logic signed [15:0] a;
    logic signed [17:0] e;
    for (int i = 0; i < 6; i++) begin
      a = (i < 2) ? ang_x : ((i < 4) ? ang_y : ang_z);
      e = 18'(a) + (((i % 2) == 1) ? Q12_HALF_PI : 18'sd0);
      if (e < -Q12_PI) begin
        e = e + Q12_TWO_PI;
      end else if (e > Q12_PI) begin
        e = e - Q12_TWO_PI;
      end
      w_nxt[i] = e[15:0];
    end
    for (int i = 0; i < 6; i++) begin
      sum4[i] = neg3_r[i] ? ((46'(lin3_r[i]) <<< 12) + sq3_r[i])
                          : ((46'(lin3_r[i]) <<< 12) - sq3_r[i]);
      sum4[i] = sum4[i] + 46'sd33554432;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        w_r[i]    <= w_nxt[i];
        lin2_r[i] <= 34'(w_r[i]) * 34'(SIN_A);
        sq1_r[i]  <= 30'(w_r[i]) * 30'(w_r[i]);
        neg2_r[i] <= w_r[i][15];
        lin3_r[i] <= lin2_r[i];
        sq3_r[i]  <= 46'(sq1_r[i]) * 46'(SIN_B);
        neg3_r[i] <= neg2_r[i];
        sn_r[i]   <= sum4[i][43:26];
      end
      p5_r    <= mul14(sn_r[0], sn_r[2]);
      q5_r    <= mul14(sn_r[1], sn_r[2]);
      cz5_r   <= sn_r[5];
      sz5_r   <= sn_r[4];
      cxsz5_r <= mul14(sn_r[1], sn_r[4]);
      cxcz5_r <= mul14(sn_r[1], sn_r[5]);
      sxsz5_r <= mul14(sn_r[0], sn_r[4]);
      sxcz5_r <= mul14(sn_r[0], sn_r[5]);
      m00_5_r <= mul14(sn_r[3], sn_r[5]);
      m01_5_r <= -mul14(sn_r[3], sn_r[4]);
      m02_5_r <= sn_r[2];
      m12_5_r <= -mul14(sn_r[0], sn_r[3]);
      m22_5_r <= mul14(sn_r[1], sn_r[3]);
      pcz6_r  <= mul14(p5_r, cz5_r);
      psz6_r  <= mul14(p5_r, sz5_r);
      qcz6_r  <= mul14(q5_r, cz5_r);
      qsz6_r  <= mul14(q5_r, sz5_r);
      cxsz6_r <= cxsz5_r;
      cxcz6_r <= cxcz5_r;
      sxsz6_r <= sxsz5_r;
      sxcz6_r <= sxcz5_r;
      m00_6_r <= m00_5_r;
      m01_6_r <= m01_5_r;
      m02_6_r <= m02_5_r;
      m12_6_r <= m12_5_r;
      m22_6_r <= m22_5_r;
      m7_r[0] <= m00_6_r;
      m7_r[1] <= m01_6_r;
      m7_r[2] <= m02_6_r;
      m7_r[3] <= pcz6_r + cxsz6_r;
      m7_r[4] <= cxcz6_r - psz6_r;
      m7_r[5] <= m12_6_r;
      m7_r[6] <= sxsz6_r - qcz6_r;
      m7_r[7] <= qsz6_r + sxcz6_r;
      m7_r[8] <= m22_6_r;
    end
  end

  assign mat.valid = v_r[7];
  assign mat.m     = m7_r;

endmodule

// ===== src/euler_rotate_cube_corners.sv =====
// Top level of the cube corner rotator: register port, corner emitter, outputs.
// Depends on erc_pkg, erc_in_if, erc_out_if, erc_matrix and the defines header.
//
//   channel  role    beat
//   in_ch    sink    angle_x, angle_y, angle_z (Q3.12 radians)
//   out_ch   source  corner_index, out_x, out_y, out_z, last_corner
//   APB      slave   five registers at byte address 4*i
//
// Each angle beat yields CORNER_COUNT result beats, one per cycle unless out_ch
// stalls; the corner emitter holds the next angle beat until the last corner issues.
// An angle beat passes the matrix pipeline, e1 and the output register first.
// Reset is synchronous and clears the valid bits, the corner counter and the APB registers.
// A stalled result holds the emitter and, once a valid matrix waits, the matrix pipeline.
`include "euler_rotate_cube_corners_defines.svh"
module euler_rotate_cube_corners #(
  parameter int CORNER_COUNT = erc_pkg::CORNER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  erc_in_if.sink      in_ch,
  erc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import erc_pkg::*;

  localparam int CNT_W = $clog2(CORNER_COUNT);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CORNER_COUNT - 1);

  logic [15:0]        shift_x_r, shift_y_r, shift_z_r, view_distance_r;
  logic [11:0]        cube_side_r;
  reg_idx_t           idx;
  logic               wr_en;

  logic signed [17:0] lo_r [3];
  logic signed [17:0] hi_r [3];
  logic signed [17:0] tr   [3];
  logic signed [17:0] half;

  mat_t               mat;
  logic               front_adv;
  logic               e_adv;
  logic               e_issue;
  logic [CNT_W-1:0]   cnt_r;
  logic [2:0]         sgn;

  logic               e1_valid_r;
  logic [CNT_W-1:0]   e1_idx_r;
  logic               e1_last_r;
  logic signed [35:0] pr_r [3][3];

  logic               out_valid_r;
  logic [2:0]         out_idx_r;
  logic               out_last_r;
  logic signed [23:0] res_r   [3];
  logic signed [23:0] res_nxt [3];

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r       <= '0;
      shift_y_r       <= '0;
      shift_z_r       <= '0;
      cube_side_r     <= '0;
      view_distance_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SHIFT_X:       shift_x_r       <= pwdata[15:0];
        REG_SHIFT_Y:       shift_y_r       <= pwdata[15:0];
        REG_SHIFT_Z:       shift_z_r       <= pwdata[15:0];
        REG_CUBE_SIDE:     cube_side_r     <= pwdata[11:0];
        REG_VIEW_DISTANCE: view_distance_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHIFT_X:       prdata = {16'd0, shift_x_r};
      REG_SHIFT_Y:       prdata = {16'd0, shift_y_r};
      REG_SHIFT_Z:       prdata = {16'd0, shift_z_r};
      REG_CUBE_SIDE:     prdata = {20'd0, cube_side_r};
      REG_VIEW_DISTANCE: prdata = {16'd0, view_distance_r};
      default:           prdata = '0;
    endcase
  end

  // Both corner coordinates per axis follow the registers in the next cycle.
  always_comb begin
    half  = $signed({3'd0, cube_side_r[11:1], 4'd0});
    tr[0] = 18'($signed(shift_x_r));
    tr[1] = 18'($signed(shift_y_r));
    tr[2] = 18'($signed(shift_z_r)) + 18'($signed(view_distance_r));
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      lo_r[a] <= tr[a] - half;
      hi_r[a] <= tr[a] + half;
    end
  end

  assign e_adv     = !out_valid_r || out_ch.ready;
  assign e_issue   = mat.valid && e_adv;
  assign front_adv = !mat.valid || (e_issue && (cnt_r == LAST_IDX));
  assign in_ch.ready = front_adv;

  erc_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (front_adv),
    .in_valid (in_ch.valid),
    .ang_x    (in_ch.angle_x),
    .ang_y    (in_ch.angle_y),
    .ang_z    (in_ch.angle_z),
    .mat      (mat)
  );

  assign sgn = corner_sign(3'(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      e1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (e_adv) begin
      e1_valid_r  <= mat.valid;
      out_valid_r <= e1_valid_r;
      if (mat.valid) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      e1_idx_r  <= cnt_r;
      e1_last_r <= (cnt_r == LAST_IDX);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pr_r[r][c] <= 36'($signed(mat.m[r*3+c]))
                        * 36'(sgn[2-c] ? hi_r[c] : lo_r[c]);
        end
      end
      out_idx_r  <= 3'(e1_idx_r);
      out_last_r <= e1_last_r;
      res_r      <= res_nxt;
    end
  end

  always_comb begin
    logic signed [37:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = 38'(pr_r[r][0]) + 38'(pr_r[r][1]) + 38'(pr_r[r][2]) + 38'sd8192;
      acc = acc >>> 14;
      if (acc > OUT_MAX) begin
        res_nxt[r] = OUT_MAX[23:0];
      end else if (acc < OUT_MIN) begin
        res_nxt[r] = OUT_MIN[23:0];
      end else begin
        res_nxt[r] = acc[23:0];
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.corner_index = out_idx_r;
  assign out_ch.out_x        = res_r[0];
  assign out_ch.out_y        = res_r[1];
  assign out_ch.out_z        = res_r[2];
  assign out_ch.last_corner  = out_last_r;

  `ERC_ASSERT(a_last_on_final, out_valid_r, out_last_r == (out_idx_r == 3'(LAST_IDX)))
  `ERC_ASSERT_NEXT(a_cnt_wraps, e_issue && (cnt_r == LAST_IDX), cnt_r == '0)
  `ERC_ASSERT(a_in_waits_on_matrix, mat.valid && !e_issue, !in_ch.ready)

endmodule
